// ===== sv/multi_source_start_gate_macros.svh =====
// Assertion macros shared by the start gate checker.
`ifndef MULTI_SOURCE_START_GATE_MACROS_SVH
`define MULTI_SOURCE_START_GATE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msg_pkg.sv =====
// Types and constants of the multi-source recording start gate.
package msg_pkg;

    localparam int NumSources = 6;
    localparam int TimeWidth  = 63;
    localparam int CfgWidth   = 40;

    localparam logic [NumSources-1:0] AllMask = '1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ARMING = 2'd1,
        PH_WAIT   = 2'd2,
        PH_OPEN   = 2'd3
    } phase_t;

    // Command codes carried in the kind field; other codes act as a tick.
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_ARM    = 3'd1;
    localparam logic [2:0] KIND_RESET  = 3'd2;
    localparam logic [2:0] KIND_READY  = 3'd3;
    localparam logic [2:0] KIND_REFINE = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_STABLE_WINDOW = 1'b0;
    localparam logic CFG_ARM_TIMEOUT   = 1'b1;

    localparam logic [CfgWidth-1:0] StableWindowReset = 40'd1500000000;
    localparam logic [CfgWidth-1:0] ArmTimeoutReset   = 40'd10000000000;

    typedef struct packed {
        logic [2:0]           kind;
        logic [2:0]           source;
        logic [TimeWidth-1:0] now_ns;
        logic [TimeWidth-1:0] exposure_ns;
    } msg_in_t;

    typedef struct packed {
        phase_t               phase;
        logic [5:0]           ready_mask;
        logic [5:0]           missing_mask;
        logic [TimeWidth-1:0] gate_time_ns;
        logic                 degraded;
        logic                 refined;
    } msg_out_t;

endpackage

// ===== sv/msg_core.sv =====
// Gate state registers, configuration registers and the per-item update logic.
module msg_core
    import msg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CfgWidth-1:0] cfg_data,
    input  logic                step,
    input  msg_in_t             item,
    output msg_out_t            result
);

    logic [CfgWidth-1:0]   stable_window_reg;
    logic [CfgWidth-1:0]   arm_timeout_reg;
    phase_t                phase_reg, phase_next;
    logic [NumSources-1:0] ready_reg, ready_next;
    logic [TimeWidth-1:0]  armed_time_reg, armed_time_next;
    logic [TimeWidth-1:0]  stable_start_reg, stable_start_next;
    logic [TimeWidth-1:0]  gate_time_reg, gate_time_next;
    logic                  refined_reg, refined_next;
    logic                  degraded_reg, degraded_next;

    logic                  arm_hit;
    logic                  stable_hit;
    logic [NumSources-1:0] src_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_window_reg <= StableWindowReset;
            arm_timeout_reg   <= ArmTimeoutReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_STABLE_WINDOW)
            begin
                stable_window_reg <= cfg_data;
            end
            else
            begin
                arm_timeout_reg <= cfg_data;
            end
        end
    end

    // Deadlines are compared in 64 bits so that start plus window never wraps.
    assign arm_hit = (phase_reg == PH_ARMING) &&
        ({1'b0, item.now_ns} >= ({1'b0, armed_time_reg} + {24'd0, arm_timeout_reg}));
    assign stable_hit = (phase_reg == PH_WAIT) &&
        ({1'b0, item.now_ns} >= ({1'b0, stable_start_reg} + {24'd0, stable_window_reg}));

    assign src_bit = NumSources'(1) << item.source;

    always_comb
    begin
        phase_next        = phase_reg;
        ready_next        = ready_reg;
        armed_time_next   = armed_time_reg;
        stable_start_next = stable_start_reg;
        gate_time_next    = gate_time_reg;
        refined_next      = refined_reg;
        degraded_next     = degraded_reg;

        if (arm_hit)
        begin
            gate_time_next = item.now_ns;
            degraded_next  = 1'b1;
            phase_next     = PH_OPEN;
        end
        else if (stable_hit)
        begin
            gate_time_next = item.now_ns;
            phase_next     = PH_OPEN;
        end

        case (item.kind)
            KIND_ARM:
            begin
                if (phase_next == PH_IDLE)
                begin
                    phase_next      = PH_ARMING;
                    ready_next      = '0;
                    gate_time_next  = '0;
                    degraded_next   = 1'b0;
                    armed_time_next = item.now_ns;
                end
            end
            KIND_RESET:
            begin
                phase_next    = PH_IDLE;
                ready_next    = '0;
                refined_next  = 1'b0;
                degraded_next = 1'b0;
            end
            KIND_READY:
            begin
                if ((phase_next == PH_ARMING) && (item.source < 3'(NumSources)) &&
                    ((ready_reg & src_bit) == '0))
                begin
                    ready_next = ready_reg | src_bit;
                    if ((ready_reg | src_bit) == AllMask)
                    begin
                        phase_next        = PH_WAIT;
                        stable_start_next = item.now_ns;
                    end
                end
            end
            KIND_REFINE:
            begin
                if ((phase_next == PH_OPEN) && !refined_reg)
                begin
                    refined_next   = 1'b1;
                    gate_time_next = item.exposure_ns;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            ready_reg        <= '0;
            armed_time_reg   <= '0;
            stable_start_reg <= '0;
            gate_time_reg    <= '0;
            refined_reg      <= 1'b0;
            degraded_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            ready_reg        <= ready_next;
            armed_time_reg   <= armed_time_next;
            stable_start_reg <= stable_start_next;
            gate_time_reg    <= gate_time_next;
            refined_reg      <= refined_next;
            degraded_reg     <= degraded_next;
        end
    end

    assign result.phase        = phase_next;
    assign result.ready_mask   = ready_next;
    assign result.missing_mask = AllMask ^ ready_next;
    assign result.gate_time_ns = gate_time_next;
    assign result.degraded     = degraded_next;
    assign result.refined      = refined_next;

endmodule

// ===== sv/multi_source_start_gate.sv =====
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the output stalls; an input register
// feeds the gate update logic that writes the result register in the same cycle.
// Stall on the output holds the result register and then the input register.
// Reset (rst_n low, asynchronous) empties both registers, sets the phase to idle,
// clears all gate state and loads the default window and timeout values.
module multi_source_start_gate
    import msg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msg_in_t             in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msg_out_t            out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CfgWidth-1:0] cfg_data
);

    logic     s1_valid_reg, s1_valid_next;
    msg_in_t  s1_item_reg;
    logic     out_valid_reg, out_valid_next;
    msg_out_t out_data_reg;
    msg_out_t result;
    logic     s1_move;
    logic     in_accept;

    // The held item advances whenever the result register is free or being taken.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_move)
        begin
            out_data_reg <= result;
        end
    end

    msg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (s1_move),
        .item      (s1_item_reg),
        .result    (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/msg_checker.sv =====
// Port-level checker for the start gate, bound to the top level.
`include "multi_source_start_gate_macros.svh"

module msg_checker
    import msg_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_stall,
    input msg_out_t out_data
);

    `MSG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")
    `MSG_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled item changed")
    `MSG_ASSERT_NOW(a_mask_split, out_valid, (out_data.ready_mask ^ out_data.missing_mask) == AllMask, "masks disagree")
    `MSG_ASSERT_NOW(a_idle_clear, out_valid && (out_data.phase == PH_IDLE), (out_data.ready_mask == '0) && !out_data.degraded && !out_data.refined, "idle with stale flags")
    `MSG_ASSERT_NOW(a_refined_open, out_valid && out_data.refined, out_data.phase == PH_OPEN, "refined while not open")

endmodule

bind multi_source_start_gate msg_checker u_msg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
